### hdl/loge_pkg.sv
`timescale 1ns / 1ps

package loge_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WEIGHT_RED   = 3'd2;
    localparam logic [2:0] REG_WEIGHT_GREEN = 3'd3;
    localparam logic [2:0] REG_WEIGHT_BLUE  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Window row source: line store slot 0..4, or the gray value in flight
    localparam logic [2:0] SRC_CUR = 3'd5;

    // Window update modes
    localparam logic [1:0] MODE_FILL  = 2'd0;  // load new column into all five taps
    localparam logic [1:0] MODE_SHIFT = 2'd1;  // shift left, new column on the right
    localparam logic [1:0] MODE_DUP   = 2'd2;  // shift left, repeat rightmost column

    // floor(x / 100) as (x * 83887) >> 23, exact for x below 91180
    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int          DIV100_SHIFT = 23;

    typedef struct packed {
        logic [1:0]      mode;
        logic            wr;
        logic            emit;
        logic            run_last;
        logic            frame_last;
        logic [2:0]      wr_slot;
        logic [4:0][2:0] src;
    } op_t;

    // Slot that held the row d rows above the row in slot s
    function automatic logic [2:0] slot_back(logic [2:0] s, logic [2:0] d);
        logic [3:0] t;
        t = {1'b0, s} + 4'd5 - {1'b0, d};
        if (t >= 4'd5) begin
            t = t - 4'd5;
        end
        return t[2:0];
    endfunction

endpackage

### hdl/log5x5_edge_filter.sv
`timescale 1ns / 1ps

// 5x5 Laplacian-of-Gaussian edge response over an RGB pixel stream. Pixels enter in
// raster order, one per clock while the output does not stall; each is turned to gray
// and kept in a five-row line store (five RAMs of MAX_WIDTH bytes, no clearing after
// reset), and a 5x5 window of registers produces the signed response with borders
// replicated. A response passes through the pixel, weighted-sum, window and output
// registers before it is on the output. The last pixel of each row from the third
// row on is held until it has released three responses through the one window. After
// the frame, drain words release the last two output rows, one response per word; the
// first drain word of each of those rows first preloads the window with columns 0..2.
// A stalled result output holds the input once the pipeline is full. Write the
// configuration registers only while the block is idle.
module log5x5_edge_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // response[12:0] (signed), zero[15:13]
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser,   // frame_last[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [loge_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [loge_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [6:0]  weight_red_reg;
    logic [6:0]  weight_green_reg;
    logic [6:0]  weight_blue_reg;

    logic [CW-1:0]   wmax;
    logic [RW-1:0]   hmax;
    logic            st1_ready;
    logic            wr_pending;
    logic            op_valid;
    loge_pkg::op_t   op;
    logic [CW-1:0]   op_col;
    logic [4:0][7:0] ram_rdata;
    logic [4:0]      ram_we;
    logic [CW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic signed [12:0] response;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 11'd512;
            image_height_reg <= 13'd512;
            weight_red_reg   <= 7'd21;
            weight_green_reg <= 7'd72;
            weight_blue_reg  <= 7'd7;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                loge_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                loge_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                loge_pkg::REG_WEIGHT_RED:   weight_red_reg   <= cfg_data[6:0];
                loge_pkg::REG_WEIGHT_GREEN: weight_green_reg <= cfg_data[6:0];
                loge_pkg::REG_WEIGHT_BLUE:  weight_blue_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size and take the last column and row index
    always_comb begin
        if (image_width_reg < 11'd3) begin
            wmax = CW'(2);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            wmax = CW'(MAX_WIDTH - 1);
        end else begin
            wmax = CW'(image_width_reg - 11'd1);
        end
        if (image_height_reg < 13'd3) begin
            hmax = RW'(2);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            hmax = RW'(MAX_HEIGHT - 1);
        end else begin
            hmax = RW'(image_height_reg - 13'd1);
        end
    end

    loge_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .is_drain   (s_tuser[0]),
        .wmax       (wmax),
        .hmax       (hmax),
        .st1_ready  (st1_ready),
        .wr_pending (wr_pending),
        .op_valid   (op_valid),
        .op         (op),
        .op_col     (op_col)
    );

    // Line store: one RAM per row slot
    for (genvar s = 0; s < 5; s++) begin : g_line
        loge_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[s]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (op_valid && st1_ready),
            .raddr (op_col),
            .rdata (ram_rdata[s])
        );
    end

    loge_pipe #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_valid     (op_valid),
        .op           (op),
        .op_col       (op_col),
        .red          (s_tdata[7:0]),
        .green        (s_tdata[15:8]),
        .blue         (s_tdata[23:16]),
        .weight_red   (weight_red_reg),
        .weight_green (weight_green_reg),
        .weight_blue  (weight_blue_reg),
        .ram_rdata    (ram_rdata),
        .st1_ready    (st1_ready),
        .wr_pending   (wr_pending),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .response     (response),
        .run_last     (m_tlast),
        .frame_last   (m_tuser[0])
    );

    assign m_tdata = {3'b000, response};

endmodule

### hdl/loge_ram.sv
`timescale 1ns / 1ps

module loge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/loge_seq.sv
`timescale 1ns / 1ps

module loge_seq #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          is_drain,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wmax,
    input  logic [$clog2(MAX_HEIGHT)-1:0] hmax,
    input  logic                          st1_ready,
    input  logic                          wr_pending,
    output logic                          op_valid,
    output loge_pkg::op_t                 op,
    output logic [$clog2(MAX_WIDTH)-1:0]  op_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [2:0]    slot_reg;
    logic          frame_done_reg;
    logic [RW-1:0] last_row_reg;
    logic [2:0]    last_slot_reg;
    logic [CW-1:0] dcol_reg;
    logic          dpass_reg;
    logic [1:0]    step_reg;

    logic          ignored;
    logic          row_end;
    logic          frame_end;
    logic          out_row;
    logic          d_first;
    logic          d_last_col;
    logic          multi;
    logic          last_step;
    logic          can_go;
    logic          accept;
    logic [CW:0]   d_ahead;

    // Decode the word on the bus
    always_comb begin
        ignored    = is_drain ? !frame_done_reg : frame_done_reg;
        row_end    = col_reg >= wmax;
        frame_end  = row_reg >= hmax;
        out_row    = row_reg >= RW'(2);
        d_first    = dcol_reg == '0;
        d_last_col = dcol_reg >= wmax;
        multi      = is_drain ? d_first : (row_end && out_row);
        last_step  = multi ? (step_reg == 2'd2) : 1'b1;
        can_go     = st1_ready && !(is_drain && wr_pending);
        op_valid   = s_tvalid && !ignored && can_go;
        s_tready   = ignored || (can_go && last_step);
        accept     = s_tvalid && s_tready && !ignored;
        d_ahead    = {1'b0, dcol_reg} + (CW+1)'(2);
    end

    // Build the operation for the current step
    always_comb begin
        logic [2:0] d;
        op     = '0;
        op_col = col_reg;
        if (!is_drain) begin
            op.wr_slot = slot_reg;
            if (step_reg == 2'd0) begin
                op.mode = (col_reg == '0) ? loge_pkg::MODE_FILL : loge_pkg::MODE_SHIFT;
                op.wr   = 1'b1;
                op.emit = out_row && (col_reg >= CW'(2));
            end else begin
                op.mode = loge_pkg::MODE_DUP;
                op.emit = 1'b1;
            end
            op.run_last = op.emit && last_step;
            for (int k = 0; k < 5; k++) begin
                d = 3'(4 - k);
                if (d == 3'd0) begin
                    op.src[k] = loge_pkg::SRC_CUR;
                end else if (row_reg < RW'(d)) begin
                    op.src[k] = (row_reg == '0) ? loge_pkg::SRC_CUR : 3'd0;
                end else begin
                    op.src[k] = loge_pkg::slot_back(slot_reg, d);
                end
            end
        end else begin
            if (d_first) begin
                op_col  = CW'(step_reg);
                op.mode = (step_reg == 2'd0) ? loge_pkg::MODE_FILL : loge_pkg::MODE_SHIFT;
                op.emit = step_reg == 2'd2;
            end else begin
                op_col  = (d_ahead > {1'b0, wmax}) ? wmax : d_ahead[CW-1:0];
                op.mode = loge_pkg::MODE_SHIFT;
                op.emit = 1'b1;
            end
            op.run_last   = op.emit;
            op.frame_last = op.emit && dpass_reg && d_last_col;
            for (int k = 0; k < 5; k++) begin
                if (dpass_reg) begin
                    d = (k <= 2) ? 3'(2 - k) : 3'd0;
                end else begin
                    d = (k <= 3) ? 3'(3 - k) : 3'd0;
                end
                op.src[k] = (last_row_reg < RW'(d)) ? 3'd0
                                                    : loge_pkg::slot_back(last_slot_reg, d);
            end
        end
    end

    // Advance position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            slot_reg       <= '0;
            frame_done_reg <= 1'b0;
            last_row_reg   <= '0;
            last_slot_reg  <= '0;
            dcol_reg       <= '0;
            dpass_reg      <= 1'b0;
            step_reg       <= '0;
        end else begin
            if (op_valid) begin
                step_reg <= last_step ? 2'd0 : step_reg + 2'd1;
            end
            if (accept) begin
                if (!is_drain) begin
                    if (row_end) begin
                        col_reg <= '0;
                        if (frame_end) begin
                            row_reg        <= '0;
                            slot_reg       <= '0;
                            frame_done_reg <= 1'b1;
                            last_row_reg   <= row_reg;
                            last_slot_reg  <= slot_reg;
                            dcol_reg       <= '0;
                            dpass_reg      <= 1'b0;
                        end else begin
                            row_reg  <= row_reg + RW'(1);
                            slot_reg <= (slot_reg == 3'd4) ? 3'd0 : slot_reg + 3'd1;
                        end
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end else begin
                    if (d_last_col) begin
                        dcol_reg <= '0;
                        if (dpass_reg) begin
                            frame_done_reg <= 1'b0;
                            dpass_reg      <= 1'b0;
                        end else begin
                            dpass_reg <= 1'b1;
                        end
                    end else begin
                        dcol_reg <= dcol_reg + CW'(1);
                    end
                end
            end
        end
    end

endmodule

### hdl/loge_pipe.sv
`timescale 1ns / 1ps

module loge_pipe #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         op_valid,
    input  loge_pkg::op_t                op,
    input  logic [$clog2(MAX_WIDTH)-1:0] op_col,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    input  logic [6:0]                   weight_red,
    input  logic [6:0]                   weight_green,
    input  logic [6:0]                   weight_blue,
    input  logic [4:0][7:0]              ram_rdata,
    output logic                         st1_ready,
    output logic                         wr_pending,
    output logic [4:0]                   ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
    output logic [7:0]                   ram_wdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic signed [12:0]           response,
    output logic                         run_last,
    output logic                         frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Stage 1: pixel registers
    logic          st1_v_reg;
    loge_pkg::op_t st1_op_reg;
    logic [CW-1:0] st1_col_reg;
    logic [7:0]    st1_r_reg;
    logic [7:0]    st1_g_reg;
    logic [7:0]    st1_b_reg;

    // Stage 2: weighted sum and line store column
    logic            st2_v_reg;
    loge_pkg::op_t   st2_op_reg;
    logic [CW-1:0]   st2_col_reg;
    logic [16:0]     st2_sum_reg;
    logic [4:0][7:0] st2_ram_reg;

    // Stage 3: window
    logic                 st3_v_reg;
    logic                 st3_emit_reg;
    logic                 st3_rl_reg;
    logic                 st3_fl_reg;
    logic [4:0][4:0][7:0] win_reg;

    // Output word
    logic               out_v_reg;
    logic signed [12:0] out_resp_reg;
    logic               out_rl_reg;
    logic               out_fl_reg;

    logic               out_ready;
    logic               st3_leave;
    logic               st3_ready;
    logic               st2_leave;
    logic               st2_ready;
    logic               st1_leave;
    logic [14:0]        p_r;
    logic [14:0]        p_g;
    logic [14:0]        p_b;
    logic [16:0]        sum;
    logic [33:0]        q_full;
    logic [10:0]        quot;
    logic [7:0]         gray;
    logic [4:0][7:0]    col_new;
    logic [11:0]        f_pos;
    logic [9:0]         f_n2;
    logic [10:0]        f_n1;
    logic signed [13:0] f_sum;

    // Handshake chain, bubbles collapse
    always_comb begin
        out_ready  = !out_v_reg || m_tready;
        st3_leave  = st3_v_reg && (!st3_emit_reg || out_ready);
        st3_ready  = !st3_v_reg || st3_leave;
        st2_leave  = st2_v_reg && st3_ready;
        st2_ready  = !st2_v_reg || st3_ready;
        st1_leave  = st1_v_reg && st2_ready;
        st1_ready  = !st1_v_reg || st2_ready;
        wr_pending = (st1_v_reg && st1_op_reg.wr) || (st2_v_reg && st2_op_reg.wr);
    end

    // Weighted sum of the color components
    always_comb begin
        p_r = {8'b0, weight_red}   * {7'b0, st1_r_reg};
        p_g = {8'b0, weight_green} * {7'b0, st1_g_reg};
        p_b = {8'b0, weight_blue}  * {7'b0, st1_b_reg};
        sum = {2'b0, p_r} + {2'b0, p_g} + {2'b0, p_b};
    end

    // Divide by 100, saturate, pick each window row's source, drive the line store write
    always_comb begin
        q_full = {17'b0, st2_sum_reg} * {17'b0, loge_pkg::DIV100_MUL};
        quot   = q_full[33:loge_pkg::DIV100_SHIFT];
        gray   = (quot > 11'd255) ? 8'hFF : quot[7:0];
        for (int k = 0; k < 5; k++) begin
            col_new[k] = gray;
            for (int s = 0; s < 5; s++) begin
                if (st2_op_reg.src[k] == 3'(s)) begin
                    col_new[k] = st2_ram_reg[s];
                end
            end
        end
        for (int s = 0; s < 5; s++) begin
            ram_we[s] = st2_leave && st2_op_reg.wr && (st2_op_reg.wr_slot == 3'(s));
        end
        ram_waddr = st2_col_reg;
        ram_wdata = gray;
    end

    // Kernel response from the window, center tap at row 2, column 2
    always_comb begin
        f_pos = {win_reg[2][2], 4'b0};
        f_n2  = {2'b0, win_reg[1][2]} + {2'b0, win_reg[3][2]}
              + {2'b0, win_reg[2][1]} + {2'b0, win_reg[2][3]};
        f_n1  = {3'b0, win_reg[0][2]} + {3'b0, win_reg[4][2]}
              + {3'b0, win_reg[2][0]} + {3'b0, win_reg[2][4]}
              + {3'b0, win_reg[1][1]} + {3'b0, win_reg[1][3]}
              + {3'b0, win_reg[3][1]} + {3'b0, win_reg[3][3]};
        f_sum = $signed({2'b0, f_pos}) - $signed({3'b0, f_n2, 1'b0})
              - $signed({3'b0, f_n1});
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_v_reg <= op_valid;
            end
            if (st2_ready) begin
                st2_v_reg <= st1_leave;
            end
            if (st3_ready) begin
                st3_v_reg <= st2_leave;
            end
            if (out_ready) begin
                out_v_reg <= st3_leave && st3_emit_reg;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (op_valid && st1_ready) begin
            st1_op_reg  <= op;
            st1_col_reg <= op_col;
            st1_r_reg   <= red;
            st1_g_reg   <= green;
            st1_b_reg   <= blue;
        end
        if (st1_leave) begin
            st2_op_reg  <= st1_op_reg;
            st2_col_reg <= st1_col_reg;
            st2_sum_reg <= sum;
            st2_ram_reg <= ram_rdata;
        end
        if (st2_leave) begin
            st3_emit_reg <= st2_op_reg.emit;
            st3_rl_reg   <= st2_op_reg.run_last;
            st3_fl_reg   <= st2_op_reg.frame_last;
            for (int k = 0; k < 5; k++) begin
                case (st2_op_reg.mode)
                    loge_pkg::MODE_FILL: begin
                        for (int c = 0; c < 5; c++) begin
                            win_reg[k][c] <= col_new[k];
                        end
                    end
                    loge_pkg::MODE_SHIFT: begin
                        for (int c = 0; c < 4; c++) begin
                            win_reg[k][c] <= win_reg[k][c+1];
                        end
                        win_reg[k][4] <= col_new[k];
                    end
                    default: begin
                        for (int c = 0; c < 4; c++) begin
                            win_reg[k][c] <= win_reg[k][c+1];
                        end
                    end
                endcase
            end
        end
        if (st3_leave && st3_emit_reg && out_ready) begin
            out_resp_reg <= f_sum[12:0];
            out_rl_reg   <= st3_rl_reg;
            out_fl_reg   <= st3_fl_reg;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign response   = out_resp_reg;
    assign run_last   = out_rl_reg;
    assign frame_last = out_fl_reg;

endmodule
